// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge, off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Condition that holds at every clock edge after reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

// ===== sv/rte_pkg.sv =====
// Package: types and constants of the resend timeout estimator.
package rte_pkg;
    localparam int Window     = 100;
    localparam int SlotW      = $clog2(Window);
    localparam int CountW     = 11;
    localparam int SumW       = 26;
    localparam int MeanW      = 34;
    localparam int AccW       = 48;
    localparam logic [15:0] DefaultTimeoutReset = 16'd20;
    localparam logic KindRecord = 1'b0;
    localparam logic KindQuery  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample_time;
        logic [31:0] elapsed_time;
        logic [31:0] override_timeout;
    } rte_in_t;

    typedef struct packed {
        logic        need_resend;
        logic [31:0] timeout_used;
        logic [10:0] samples_held;
    } rte_out_t;

    // Shared divider / square-root unit control.
    typedef enum logic [1:0] {
        OP_DIV  = 2'd0,
        OP_SQRT = 2'd1
    } rte_op_t;

    typedef struct packed {
        logic            start;
        rte_op_t         op;
        logic [AccW-1:0] num;
        logic [CountW-1:0] den;
    } rte_unit_req_t;

    typedef struct packed {
        logic            done;
        logic [AccW-1:0] result;
    } rte_unit_rsp_t;
endpackage

// ===== sv/resend_timeout_estimator.sv =====
// Top level of the resend timeout estimator.
// Resend timeout estimator: record items store an acknowledgement time in a
// 100-entry window and offer their result after the S_REC_RD, S_REC_WAIT,
// S_REC_WR and S_OUT states; queries with a nonzero override or an empty
// window go straight to S_OUT. Other queries compute floor(mean) + 2*floor(sd)
// with two divides and one square root on the one shared bit-serial unit, one
// window RAM read per stored time plus a drain of the sweep pipeline, and
// handoff states between them. One item is in work at a time; in_ready is low
// until the result has been taken, and the next transaction can be accepted
// on the cycle after that.
module resend_timeout_estimator
    import rte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  rte_pkg::rte_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rte_pkg::rte_out_t out_data
);
    logic             ram_we;
    logic [SlotW-1:0] ram_addr;
    logic [15:0]      ram_wdata;
    logic [15:0]      ram_rdata;
    rte_unit_req_t    unit_req;
    rte_unit_rsp_t    unit_rsp;

    rte_seq u_seq (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .ram_we(ram_we), .ram_addr(ram_addr), .ram_wdata(ram_wdata),
        .ram_rdata(ram_rdata), .unit_req(unit_req), .unit_rsp(unit_rsp)
    );

    rte_unit u_unit (.clk(clk), .rst_n(rst_n), .req(unit_req), .rsp(unit_rsp));

    rte_ram #(.Width(16), .Depth(Window)) u_window (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );
endmodule

// ===== sv/rte_ram.sv =====
// Generic single-port RAM with registered read.
module rte_ram #(
    parameter int Width = 16,
    parameter int Depth = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Registered read; on a write the old word is returned
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/rte_unit.sv =====
// Shared iterative unit: restoring divide or bitwise integer square root.
module rte_unit
    import rte_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rte_unit_req_t req,
    output rte_unit_rsp_t rsp
);
    `include "assert_macros.svh"

    localparam int StepW = $clog2(AccW + 1);

    logic            busy_reg, busy_next;
    rte_op_t         op_reg, op_next;
    logic [AccW-1:0] a_reg, a_next;      // dividend/quotient or radicand
    logic [AccW-1:0] r_reg, r_next;      // remainder or root
    logic [AccW-1:0] b_reg, b_next;      // divisor or sqrt bit
    logic [StepW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;

    logic [AccW:0]   rem_sh;
    logic [AccW:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_sh    = {r_reg, a_reg[AccW-1]};
        trial     = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            a_next    = req.num;
            r_next    = '0;
            cnt_next  = StepW'(AccW / 2);
            if (req.op == OP_DIV)
            begin
                b_next   = AccW'(req.den);
                cnt_next = StepW'(AccW);
            end
            else
            begin
                b_next = AccW'(1) << (AccW - 2);
            end
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_DIV:
                begin
                    // One quotient bit per cycle
                    trial = rem_sh - {1'b0, b_reg};
                    a_next = {a_reg[AccW-2:0], ~trial[AccW]};
                    r_next = trial[AccW] ? rem_sh[AccW-1:0] : trial[AccW-1:0];
                end
                OP_SQRT:
                begin
                    // One root bit per cycle
                    trial = {1'b0, a_reg} - {1'b0, r_reg + b_reg};
                    if (!trial[AccW])
                    begin
                        a_next = trial[AccW-1:0];
                        r_next = (r_reg >> 1) + b_reg;
                    end
                    else
                    begin
                        r_next = r_reg >> 1;
                    end
                    b_next = b_reg >> 2;
                end
                default:
                begin
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == StepW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == OP_DIV) ? a_reg : r_reg;

    `ASSERT_IMPL(a_no_restart, clk, rst_n, !(req.start && busy_reg), "start while busy")
    `ASSERT_IMPL(a_done_after_busy, clk, rst_n, !done_reg || $past(busy_reg), "done not after busy")
    `ASSERT_ALWAYS(a_cnt_idle, clk, rst_n, busy_reg || cnt_reg == '0, "count left over")
endmodule

// ===== sv/rte_seq.sv =====
// Sequencer: window bookkeeping, deviation sweep and result register.
module rte_seq
    import rte_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  rte_pkg::rte_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rte_pkg::rte_out_t   out_data,
    output logic                ram_we,
    output logic [rte_pkg::SlotW-1:0] ram_addr,
    output logic [15:0]         ram_wdata,
    input  logic [15:0]         ram_rdata,
    output rte_pkg::rte_unit_req_t unit_req,
    input  rte_pkg::rte_unit_rsp_t unit_rsp
);
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_REC_RD, S_REC_WAIT, S_REC_WR, S_MEAN, S_MEAN_W,
        S_SWEEP_RD, S_SWEEP_ACC, S_VAR, S_VAR_W, S_SQRT, S_SQRT_W, S_OUT
    } state_t;

    state_t            state_reg;
    logic [CountW-1:0] fill_reg;
    logic [SlotW-1:0]  slot_reg;
    logic [SumW-1:0]   sum_reg;
    logic [15:0]       deft_reg;
    rte_in_t           item_reg;
    logic [MeanW-1:0]  mean_reg;
    logic [AccW-1:0]   acc_reg;
    logic [SlotW-1:0]  idx_reg;
    logic              rd_pend_reg;
    logic [31:0]       dev_sq_reg;
    logic              dev_pend_reg;
    rte_out_t          out_reg;
    logic              out_valid_reg;

    logic [23:0]       s_q8;
    logic [23:0]       dev;
    logic [31:0]       dev_sq;
    logic [SlotW-1:0]  last_idx;
    logic [SlotW-1:0]  slot_inc;
    logic [31:0]       est;

    // Deviation of the stored time from the mean; mean < 2^24
    assign s_q8   = {ram_rdata, 8'd0};
    assign dev    = (s_q8 >= mean_reg[23:0]) ? s_q8 - mean_reg[23:0] : mean_reg[23:0] - s_q8;
    assign dev_sq = 32'((48'(dev) * 48'(dev)) >> 16);
    assign last_idx = SlotW'(fill_reg - 1'b1);
    assign slot_inc = (slot_reg == SlotW'(Window - 1)) ? '0 : slot_reg + 1'b1;
    assign est    = 32'(mean_reg[MeanW-1:8]) + {unit_rsp.result[30:0], 1'b0};

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        ram_we    = (state_reg == S_REC_WR);
        ram_addr  = (state_reg == S_SWEEP_RD) ? idx_reg : slot_reg;
        ram_wdata = item_reg.sample_time;
        unit_req  = '0;
        unit_req.den = fill_reg;
        unit_req.op  = OP_DIV;
        unique case (state_reg)
            S_MEAN:
            begin
                unit_req.start = 1'b1;
                unit_req.num   = AccW'({sum_reg, 8'd0});
            end
            S_VAR:
            begin
                unit_req.start = 1'b1;
                unit_req.num   = acc_reg;
            end
            S_SQRT:
            begin
                unit_req.start = 1'b1;
                unit_req.op    = OP_SQRT;
                unit_req.num   = unit_rsp.result;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            deft_reg      <= DefaultTimeoutReset;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            dev_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                deft_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg <= in_data;
                        if (in_data.kind == KindRecord)
                        begin
                            state_reg <= S_REC_RD;
                        end
                        else if (in_data.override_timeout != 32'd0)
                        begin
                            out_reg.need_resend  <= in_data.elapsed_time >= in_data.override_timeout;
                            out_reg.timeout_used <= in_data.override_timeout;
                            out_reg.samples_held <= fill_reg;
                            state_reg <= S_OUT;
                        end
                        else if (fill_reg == '0)
                        begin
                            out_reg.need_resend  <= in_data.elapsed_time >= 32'(deft_reg);
                            out_reg.timeout_used <= 32'(deft_reg);
                            out_reg.samples_held <= fill_reg;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_MEAN;
                        end
                    end
                end
                // Fetch the oldest entry being replaced
                S_REC_RD:   state_reg <= S_REC_WAIT;
                S_REC_WAIT: state_reg <= S_REC_WR;
                S_REC_WR:
                begin
                    if (fill_reg == CountW'(Window))
                    begin
                        sum_reg <= sum_reg - SumW'(ram_rdata) + SumW'(item_reg.sample_time);
                        out_reg.samples_held <= fill_reg;
                    end
                    else
                    begin
                        sum_reg  <= sum_reg + SumW'(item_reg.sample_time);
                        fill_reg <= fill_reg + 1'b1;
                        out_reg.samples_held <= fill_reg + 1'b1;
                    end
                    slot_reg <= slot_inc;
                    out_reg.need_resend  <= 1'b0;
                    out_reg.timeout_used <= '0;
                    state_reg <= S_OUT;
                end
                S_MEAN:     state_reg <= S_MEAN_W;
                S_MEAN_W:
                begin
                    if (unit_rsp.done)
                    begin
                        mean_reg     <= MeanW'(unit_rsp.result);
                        acc_reg      <= '0;
                        idx_reg      <= '0;
                        rd_pend_reg  <= 1'b0;
                        dev_pend_reg <= 1'b0;
                        state_reg    <= S_SWEEP_RD;
                    end
                end
                // Pipelined sweep: address, read data, square, accumulate
                S_SWEEP_RD:
                begin
                    rd_pend_reg <= 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        state_reg <= S_SWEEP_ACC;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rd_pend_reg)
                    begin
                        dev_sq_reg   <= dev_sq;
                        dev_pend_reg <= 1'b1;
                    end
                    if (dev_pend_reg)
                    begin
                        acc_reg <= acc_reg + AccW'(dev_sq_reg);
                    end
                end
                S_SWEEP_ACC:
                begin
                    rd_pend_reg <= 1'b0;
                    if (rd_pend_reg)
                    begin
                        dev_sq_reg   <= dev_sq;
                        dev_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        dev_pend_reg <= 1'b0;
                    end
                    if (dev_pend_reg)
                    begin
                        acc_reg <= acc_reg + AccW'(dev_sq_reg);
                    end
                    if (!rd_pend_reg && !dev_pend_reg)
                    begin
                        state_reg <= S_VAR;
                    end
                end
                S_VAR:      state_reg <= S_VAR_W;
                S_VAR_W:
                begin
                    if (unit_rsp.done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:     state_reg <= S_SQRT_W;
                S_SQRT_W:
                begin
                    if (unit_rsp.done)
                    begin
                        out_reg.need_resend  <= item_reg.elapsed_time >= est;
                        out_reg.timeout_used <= est;
                        out_reg.samples_held <= fill_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_fill_range, clk, rst_n, fill_reg <= CountW'(Window), "fill over window")
    `ASSERT_ALWAYS(a_slot_range, clk, rst_n, slot_reg < SlotW'(Window), "slot over window")
    `ASSERT_IMPL(a_ready_idle, clk, rst_n, !in_ready || state_reg == S_IDLE, "ready while busy")
endmodule

// ===== tb/sv/tb_resend_timeout_estimator.sv =====
// Testbench for the resend timeout estimator: random and directed transactions with a scoreboard.
class rte_scoreboard;
    rte_pkg::rte_out_t pending_q[$];
    logic [15:0] ack_times[100];
    int unsigned fill;
    int unsigned slot;
    int unsigned time_sum;
    logic [15:0] dflt_timeout;
    int unsigned errors;

    function new();
        fill = 0;
        slot = 0;
        time_sum = 0;
        dflt_timeout = rte_pkg::DefaultTimeoutReset;
        errors = 0;
    endfunction

    // Exact integer square root by bit-pair search.
    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Mean plus two standard deviations over the window.
    function logic [31:0] timeout_estimate();
        longint unsigned mean_q8;
        longint unsigned sq_sum;
        longint unsigned s;
        longint unsigned d;
        if (fill == 0)
            return {16'd0, dflt_timeout};
        mean_q8 = (longint'(time_sum) << 8) / fill;
        sq_sum = 0;
        for (int i = 0; i < fill; i++)
        begin
            s = longint'(ack_times[i]) << 8;
            d = (s >= mean_q8) ? s - mean_q8 : mean_q8 - s;
            sq_sum += (d * d) >> 16;
        end
        return 32'((mean_q8 >> 8) + 2 * int_sqrt(sq_sum / fill));
    endfunction

    function void note_input(rte_pkg::rte_in_t t);
        rte_pkg::rte_out_t r;
        logic [31:0] tmo;
        if (t.kind == rte_pkg::KindRecord)
        begin
            if (fill >= 100)
                time_sum -= ack_times[slot];
            else
                fill++;
            ack_times[slot] = t.sample_time;
            time_sum = (time_sum + t.sample_time) & 32'h3FF_FFFF;
            slot = (slot + 1 >= 100) ? 0 : slot + 1;
            r.need_resend = 1'b0;
            r.timeout_used = '0;
        end
        else
        begin
            tmo = (t.override_timeout != 0) ? t.override_timeout : timeout_estimate();
            r.need_resend = (t.elapsed_time >= tmo);
            r.timeout_used = tmo;
        end
        r.samples_held = 11'(fill);
        pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(rte_pkg::rte_out_t got);
        rte_pkg::rte_out_t exp_r;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
        end
        exp_r = pending_q[0];
        pending_q.delete(0);
        if (got.need_resend !== exp_r.need_resend)
        begin
            $display("%0t: need_resend expected %0d actual %0d", $time,
                     exp_r.need_resend, got.need_resend);
            errors++;
        end
        if (got.timeout_used !== exp_r.timeout_used)
        begin
            $display("%0t: timeout_used expected %0d actual %0d", $time,
                     exp_r.timeout_used, got.timeout_used);
            errors++;
        end
        if (got.samples_held !== exp_r.samples_held)
        begin
            $display("%0t: samples_held expected %0d actual %0d", $time,
                     exp_r.samples_held, got.samples_held);
            errors++;
        end
    endfunction
endclass

module tb_resend_timeout_estimator;
    import rte_pkg::*;

    localparam int IdleLimit = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    rte_in_t   in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    rte_out_t  out_data;

    rte_scoreboard sb;
    bit        long_hold = 1'b0;
    bit        hold_done = 1'b0;
    int unsigned idle_cycles = 0;

    always #5 clk = ~clk;

    resend_timeout_estimator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Mostly short gaps, occasionally long ones.
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Offer one transaction and wait until it is accepted; valid stays up
    // when the next transaction follows without a gap.
    task automatic send_item(rte_in_t t);
        int unsigned g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        do @(posedge clk); while (!in_ready);
        sb.note_input(t);
    endtask

    task automatic send_record(logic [15:0] s);
        rte_in_t t;
        t = '0;
        t.kind = KindRecord;
        t.sample_time = s;
        t.elapsed_time = $urandom;
        t.override_timeout = $urandom;
        send_item(t);
    endtask

    task automatic send_query(logic [31:0] el, logic [31:0] ov);
        rte_in_t t;
        t = '0;
        t.kind = KindQuery;
        t.sample_time = 16'($urandom);
        t.elapsed_time = el;
        t.override_timeout = ov;
        send_item(t);
    endtask

    // Wait for all results, then a quiet margin before a register write.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_default(logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.dflt_timeout = v;
    endtask

    // Random phase: records with near-typical times, queries around the estimate.
    task automatic random_phase(int unsigned n, int unsigned spread);
        logic [15:0] base;
        logic [31:0] el;
        base = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_record(16'($urandom));
                else
                    send_record(16'(base + $urandom_range(0, spread)));
            end
            else
            begin
                el = $urandom_range(0, 3) == 0 ? $urandom
                                               : 32'(base) + $urandom_range(0, 3 * spread);
                send_query(el, $urandom_range(0, 2) == 0 ? $urandom : 32'd0);
            end
        end
    endtask

    // Sink side: random stalls, plus one long hold-off.
    always @(posedge clk)
    begin
        if (long_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 1) == 0);
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process.
    initial
    begin
        wait (hold_done);
        long_hold = 1'b1;
        repeat (2000) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty window, default timeout and overrides, then queries over a small window of records.
        send_query(32'd19, 32'd0);
        send_query(32'd20, 32'd0);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_query(32'd0, 32'd1);
        send_query(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        drain();
        write_default(16'hFFFF);
        send_query(32'd65535, 32'd0);
        send_query(32'd65534, 32'd0);
        drain();
        write_default(16'd0);
        send_query(32'd0, 32'd0);
        send_record(16'd0);
        send_record(16'hFFFF);
        send_query(32'd0, 32'd0);
        send_query(32'hFFFF_FFFF, 32'd0);
        send_record(16'h5555);
        send_record(16'hAAAA);
        send_query(32'd50000, 32'd0);
        send_query(32'd7, 32'd7);

        // Fill past the window so the oldest entries drop out.
        hold_done = 1'b1;
        for (int i = 0; i < 110; i++)
            send_record(16'hFFFF - 16'(i));
        send_query(32'd65535, 32'd0);
        send_query(32'd0, 32'd0);
        drain();
        write_default(16'd1234);

        random_phase(200, 50);
        drain();
        write_default(16'($urandom));
        random_phase(150, 4000);
        drain();
        write_default(16'd20);
        random_phase(100, 65535);

        drain();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
